// File: rtl/u16u8_pkg.sv
// Shared types, constants and byte-forming functions of the UTF-16 to UTF-8 encoder.
`default_nettype none
package u16u8_pkg;

  localparam int MAX_WORDS   = 65535;
  localparam int COUNT_W     = 18;
  localparam int COUNT_FIELD = (1 << COUNT_W) - 1;
  localparam int COUNT_CAP   = (3 * MAX_WORDS > COUNT_FIELD) ? COUNT_FIELD : 3 * MAX_WORDS;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(COUNT_CAP);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } unit_req_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               run_last;
    logic               string_end;
    logic [COUNT_W-1:0] byte_count;
  } byte_req_t;

  typedef struct packed {
    logic [20:0] cp;
    logic [1:0]  last_idx;
    logic        run_last;
    logic        string_end;
  } job_t;

  function automatic logic [1:0] utf8_last_idx(input logic [20:0] cp);
    logic [1:0] r;
    if (cp < 21'h80) begin
      r = 2'd0;
    end else if (cp < 21'h800) begin
      r = 2'd1;
    end else if (cp < 21'h10000) begin
      r = 2'd2;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] last_idx,
                                           input logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (last_idx)
      2'd0: b = cp[7:0];
      2'd1: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      2'd2: begin
        case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// File: rtl/u16u8_if.sv
// Valid/ready channel interfaces for code units and output bytes.
`default_nettype none
interface u16u8_unit_if;
  import u16u8_pkg::*;
  logic      valid;
  logic      ready;
  unit_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface u16u8_byte_if;
  import u16u8_pkg::*;
  logic      valid;
  logic      ready;
  byte_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/u16u8_queue.sv
// Short job queue between the classifier and the byte sequencer.
`default_nettype none
module u16u8_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire u16u8_pkg::job_t push_job_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output u16u8_pkg::job_t      head_o
);
  import u16u8_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("job pushed into full queue");

endmodule
`default_nettype wire

// File: rtl/u16u8_front.sv
// Accepts code units, pairs surrogates and issues code-point jobs.
`default_nettype none
module u16u8_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  u16u8_unit_if.sink       unit_i,
  input  wire logic        full_i,
  output logic             push_o,
  output u16u8_pkg::job_t  job_o
);
  import u16u8_pkg::*;

  logic        pend_q, pend_d;
  logic [9:0]  hb_q, hb_d;
  logic        second_q, second_d;
  job_t        second_job_q, second_job_d;
  logic        acc, is_high, is_low, last;
  logic [15:0] unit;
  logic [20:0] pair_cp, lone_cp, unit_cp;

  assign unit    = unit_i.data.code_unit;
  assign last    = unit_i.data.last_unit;
  assign is_high = unit inside {[HIGH_FIRST:HIGH_LAST]};
  assign is_low  = unit inside {[LOW_FIRST:LOW_LAST]};
  assign unit_i.ready = !second_q && !full_i;
  assign acc     = unit_i.valid && unit_i.ready;

  assign pair_cp = ({11'd0, hb_q} << 10) + {11'd0, unit[9:0]} + SUPP_BASE;
  assign lone_cp = {5'd0, HIGH_FIRST | {6'd0, hb_q}};
  assign unit_cp = {5'd0, unit};

  always_comb begin
    pend_d       = pend_q;
    hb_d         = hb_q;
    second_d     = second_q;
    second_job_d = second_job_q;
    push_o       = 1'b0;
    job_o        = '{cp: unit_cp, last_idx: utf8_last_idx(unit_cp), run_last: 1'b1,
                     string_end: last};
    if (second_q) begin
      job_o = second_job_q;
      if (!full_i) begin
        push_o   = 1'b1;
        second_d = 1'b0;
      end
    end else if (acc) begin
      if (pend_q) begin
        if (is_low) begin
          push_o = 1'b1;
          job_o  = '{cp: pair_cp, last_idx: 2'd3, run_last: 1'b1, string_end: last};
          pend_d = 1'b0;
        end else if (is_high && !last) begin
          push_o = 1'b1;
          job_o  = '{cp: lone_cp, last_idx: 2'd2, run_last: 1'b1, string_end: 1'b0};
          hb_d   = unit[9:0];
        end else begin
          push_o       = 1'b1;
          job_o        = '{cp: lone_cp, last_idx: 2'd2, run_last: 1'b0, string_end: 1'b0};
          second_d     = 1'b1;
          second_job_d = '{cp: unit_cp, last_idx: utf8_last_idx(unit_cp), run_last: 1'b1,
                           string_end: last};
          pend_d       = 1'b0;
        end
      end else if (is_high && !last) begin
        pend_d = 1'b1;
        hb_d   = unit[9:0];
      end else begin
        push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 1'b0;
      hb_q     <= '0;
      second_q <= 1'b0;
    end else begin
      pend_q   <= pend_d;
      hb_q     <= hb_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    second_job_q <= second_job_d;
  end

  a_second_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> !unit_i.ready)
    else $error("request accepted while second job waits");

  a_second_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> !pend_q)
    else $error("surrogate held while second job waits");

endmodule
`default_nettype wire

// File: rtl/u16u8_back.sv
// Expands queued code points into UTF-8 bytes with a running byte count.
`default_nettype none
module u16u8_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            empty_i,
  input  wire u16u8_pkg::job_t head_i,
  output logic                 pop_o,
  u16u8_byte_if.source         byte_o
);
  import u16u8_pkg::*;

  logic [1:0]         idx_q, idx_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d, cnt_inc;
  logic               out_valid_q, out_valid_d;
  byte_req_t          out_q, out_d;
  logic               advance, final_byte;

  assign advance    = !empty_i && (!out_valid_q || byte_o.ready);
  assign final_byte = (idx_q == head_i.last_idx);
  assign pop_o      = advance && final_byte;
  assign cnt_inc    = (cnt_q < COUNT_LIMIT) ? cnt_q + 1'b1 : cnt_q;

  always_comb begin
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d      = 1'b1;
      out_d.out_byte   = utf8_byte(head_i.cp, head_i.last_idx, idx_q);
      out_d.run_last   = final_byte && head_i.run_last;
      out_d.string_end = final_byte && head_i.string_end;
      out_d.byte_count = cnt_inc;
      cnt_d            = (final_byte && head_i.string_end) ? '0 : cnt_inc;
      idx_d            = final_byte ? 2'd0 : idx_q + 1'b1;
    end else if (byte_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign byte_o.valid = out_valid_q;
  assign byte_o.data  = out_q;

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (idx_q <= head_i.last_idx))
    else $error("byte index past end of code point");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && final_byte && head_i.string_end) |=> (cnt_q == '0))
    else $error("byte count not cleared after string end");

endmodule
`default_nettype wire

// File: rtl/utf16_to_utf8_stream_encoder.sv
// Top level of the UTF-16 to UTF-8 stream encoder.
//
//   channel   dir   payload                                         request
//   unit_i    in    code_unit[15:0], last_unit                      one code unit
//   byte_o    out   out_byte[7:0], run_last, string_end, count[17:0] one UTF-8 byte
//
// One output byte per cycle while jobs are queued and byte_o is ready; a code unit gives 1 to 3
// bytes, a surrogate pair 4, and a broken pair 3 plus the following unit's bytes.
// A unit is accepted each cycle the job queue has room and no broken-pair job waits.
// A high surrogate that is not last is held in the front until the next unit arrives.
// Reset clears the held surrogate, the queue and the byte count.
// byte_o stalls hold the output register; the queue then fills and unit_i stalls.
`default_nettype none
module utf16_to_utf8_stream_encoder (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  u16u8_unit_if.sink    unit_i,
  u16u8_byte_if.source  byte_o
);
  import u16u8_pkg::*;

  logic push, pop, full, empty;
  job_t push_job, head;

  u16u8_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .unit_i (unit_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  u16u8_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  u16u8_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .byte_o  (byte_o)
  );

endmodule
`default_nettype wire

// File: sim/utf16_to_utf8_stream_encoder_test.sv
// Self-checking testbench of the UTF-16 to UTF-8 stream encoder.
`timescale 1ns / 1ps
module utf16_to_utf8_stream_encoder_test;
  import u16u8_pkg::*;

  localparam int LIMIT_CYCLES = 100000;
  localparam int RANDOM_UNITS = 186;
  localparam int DRAIN_CYCLES = 40;

  class utf8_byte_scoreboard;
    byte_req_t          expected_q[$];
    bit                 held_valid;
    logic [9:0]         held_bits;
    logic [COUNT_W-1:0] string_bytes;
    int                 mismatches;
    int                 bytes_checked;
    int                 saturated_bytes;
    int                 units_noted;
    int                 strings_noted;
    int                 pairs_seen;
    int                 unpaired_seen;

    function new();
      held_valid      = 1'b0;
      held_bits       = '0;
      string_bytes    = '0;
      mismatches      = 0;
      bytes_checked   = 0;
      saturated_bytes = 0;
      units_noted     = 0;
      strings_noted   = 0;
      pairs_seen      = 0;
      unpaired_seen   = 0;
    endfunction

    function void push_byte(logic [7:0] b);
      byte_req_t r;
      if (string_bytes < COUNT_LIMIT) string_bytes = string_bytes + 1'b1;
      r.out_byte   = b;
      r.run_last   = 1'b0;
      r.string_end = 1'b0;
      r.byte_count = string_bytes;
      expected_q.push_back(r);
    endfunction

    function void push_code_point(logic [20:0] cp);
      if (cp < 21'h80) begin
        push_byte(cp[7:0]);
      end else if (cp < 21'h800) begin
        push_byte({3'b110, cp[10:6]});
        push_byte({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
        push_byte({4'b1110, cp[15:12]});
        push_byte({2'b10, cp[11:6]});
        push_byte({2'b10, cp[5:0]});
      end else begin
        push_byte({5'b11110, cp[20:18]});
        push_byte({2'b10, cp[17:12]});
        push_byte({2'b10, cp[11:6]});
        push_byte({2'b10, cp[5:0]});
      end
    endfunction

    function void note_unit(unit_req_t u);
      bit        is_high;
      bit        is_low;
      bit        paired;
      int        first;
      byte_req_t tail;
      is_high = (u.code_unit >= HIGH_FIRST) && (u.code_unit <= HIGH_LAST);
      is_low  = (u.code_unit >= LOW_FIRST) && (u.code_unit <= LOW_LAST);
      paired  = 1'b0;
      first   = expected_q.size();
      units_noted++;
      if (held_valid) begin
        if (is_low) begin
          push_code_point(21'({held_bits, u.code_unit[9:0]}) + SUPP_BASE);
          pairs_seen++;
          paired = 1'b1;
        end else begin
          push_code_point(21'(HIGH_FIRST | {6'd0, held_bits}));
          unpaired_seen++;
        end
        held_valid = 1'b0;
        held_bits  = '0;
      end
      if (!paired) begin
        if (is_high && !u.last_unit) begin
          held_valid = 1'b1;
          held_bits  = u.code_unit[9:0];
        end else begin
          if (is_high || is_low) unpaired_seen++;
          push_code_point(21'(u.code_unit));
        end
      end
      if (expected_q.size() > first) begin
        tail = expected_q.pop_back();
        tail.run_last = 1'b1;
        if (u.last_unit) begin
          tail.string_end = 1'b1;
          string_bytes    = '0;
          strings_noted++;
        end
        expected_q.push_back(tail);
      end
    endfunction

    function void check_byte(byte_req_t got);
      byte_req_t want;
      bytes_checked++;
      if (got.byte_count == COUNT_LIMIT) saturated_bytes++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected byte: byte=%02h run_last=%0d end=%0d count=%0d",
                   got.out_byte, got.run_last, got.string_end, got.byte_count);
      end else begin
        want = expected_q.pop_front();
        if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
            got.string_end !== want.string_end || got.byte_count !== want.byte_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("byte mismatch: exp %02h/%0d/%0d/%0d got %02h/%0d/%0d/%0d",
                     want.out_byte, want.run_last, want.string_end, want.byte_count,
                     got.out_byte, got.run_last, got.string_end, got.byte_count);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int   cycle_count = 0;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   random_sent;

  utf8_byte_scoreboard sb = new();

  u16u8_unit_if unit_bus ();
  u16u8_byte_if byte_bus ();

  utf16_to_utf8_stream_encoder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .unit_i (unit_bus),
    .byte_o (byte_bus)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    byte_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && byte_bus.valid && byte_bus.ready) sb.check_byte(byte_bus.data);
      byte_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_unit(input logic [15:0] code, input logic last);
    unit_req_t u;
    u.code_unit = code;
    u.last_unit = last;
    while ($urandom_range(99) < send_idle_pct) begin
      unit_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    unit_bus.valid <= 1'b1;
    unit_bus.data  <= u;
    @(posedge clk_i);
    while (!unit_bus.ready) @(posedge clk_i);
    sb.note_unit(u);
  endtask

  task automatic send_random_string();
    int          len;
    int          k;
    int          kind;
    logic [15:0] cu;
    len = $urandom_range(1, 8);
    k   = 0;
    while (k < len) begin
      kind = $urandom_range(0, 11);
      case (kind)
        0:       cu = 16'($urandom_range(16'h0000, 16'h007F));
        1:       cu = 16'($urandom_range(16'h0080, 16'h07FF));
        2:       cu = 16'($urandom_range(16'h0800, 16'hD7FF));
        3:       cu = 16'($urandom_range(16'hE000, 16'hFFFF));
        4, 5, 6: cu = 16'($urandom_range(HIGH_FIRST, HIGH_LAST));
        7:       cu = 16'($urandom_range(LOW_FIRST, LOW_LAST));
        default: cu = 16'($urandom_range(0, 16'hFFFF));
      endcase
      if (kind >= 4 && kind <= 6 && k + 1 < len) begin
        send_unit(cu, 1'b0);
        send_unit(16'($urandom_range(LOW_FIRST, LOW_LAST)), (k + 2 >= len));
        k = k + 2;
        random_sent = random_sent + 2;
      end else begin
        send_unit(cu, (k + 1 >= len));
        k = k + 1;
        random_sent = random_sent + 1;
      end
    end
  endtask

  task automatic run_random_phase(input int units);
    int stop_at;
    stop_at = random_sent + units;
    while (random_sent < stop_at) send_random_string();
  endtask

  initial begin
    rst_ni         <= 1'b0;
    unit_bus.valid <= 1'b0;
    unit_bus.data  <= '0;
    send_idle_pct  = 23;
    recv_idle_pct  = 75;
    random_sent    = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_unit(16'h0000, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b1);
    send_unit(16'hD83D, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'hDA00, 1'b0);
    send_unit(16'hD801, 1'b0);
    send_unit(16'hDE00, 1'b0);
    send_unit(16'hDB40, 1'b0);
    send_unit(16'hD9AB, 1'b1);
    send_unit(16'hDBFF, 1'b1);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDFFF, 1'b1);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    send_unit(16'h5555, 1'b0);
    send_unit(16'hAAAA, 1'b1);

    run_random_phase(RANDOM_UNITS / 3);
    send_idle_pct = 75;
    recv_idle_pct = 23;
    run_random_phase(RANDOM_UNITS / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(RANDOM_UNITS - 2 * (RANDOM_UNITS / 3));

    send_unit(16'h00E9, 1'b1);
    send_unit(16'hD800, 1'b1);
    unit_bus.valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d code units in %0d strings: %0d pairs, %0d unpaired surrogates.",
             sb.units_noted, sb.strings_noted, sb.pairs_seen, sb.unpaired_seen);
    $display("Checked %0d UTF-8 bytes, %0d at the saturated count; %0d mismatches.",
             sb.bytes_checked, sb.saturated_bytes, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
